FILE: rtl/core/hsa_pkg.sv
// ----------------------------------------------------------------------------
// hsa_pkg
// shared widths, constants and stage types of the hsv saturation adjust block
// ----------------------------------------------------------------------------
`default_nettype none

package hsa_pkg;

    localparam int CH_W         = 8;
    localparam int NUM_CH       = 3;
    localparam int PIX_W        = CH_W * NUM_CH;
    localparam int GAIN_W       = 12;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 12'd256;
    localparam int GAIN_FRAC    = 8;

    localparam int PROD_W       = 2 * CH_W;
    localparam int REM_W        = PROD_W + 1;
    localparam int GPROD_W      = CH_W + GAIN_W;

    localparam int DIV_BITS_PER = 2;
    localparam int DIV_STAGES   = CH_W / DIV_BITS_PER;

    // input reg, product reg, prep reg, divider stages, output reg
    localparam int PIPE_DEPTH   = 3 + DIV_STAGES + 1;

    typedef logic [CH_W-1:0] t_ch;

    typedef struct packed {
        t_ch [NUM_CH-1:0]        ch;
        t_ch                     v;
        t_ch                     delta;
        logic                    grey;
        logic                    sel;
        t_ch [NUM_CH-1:0]        dg;
        logic [NUM_CH-1:0][REM_W-1:0] rem;
        t_ch [NUM_CH-1:0]        q;
    } t_div;

endpackage

`default_nettype wire

FILE: rtl/core/hsv_saturation_adjust.sv
// ----------------------------------------------------------------------------
// hsv_saturation_adjust
// scales hsv saturation of an rgb pixel by a q4.8 gain, hue and value kept
// ----------------------------------------------------------------------------
// One pixel is accepted every clock cycle while the output side does not
// stall. The pipeline is built around the restoring divider that computes
// the saturation-limited drop: four register stages, two quotient bits
// each, one divider per channel. Before that come an input stage (max, min,
// differences), a multiplier stage and a preparation stage (compare,
// rounding, dividend); after it the output register. A stall on the output
// holds the whole pipeline. The gain register takes a write in any cycle
// and must only change while no pixel is in flight.
`default_nettype none

module hsv_saturation_adjust (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // configuration write
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire [hsa_pkg::GAIN_W-1:0] i_cfg_data,     // saturation_gain
    // pixel in
    input  wire                       i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire [hsa_pkg::PIX_W-1:0]  i_s_axis_tdata, // red_in, green_in, blue_in
    // pixel out
    output logic                      o_m_axis_tvalid,
    input  wire                       i_m_axis_tready,
    output logic [hsa_pkg::PIX_W-1:0] o_m_axis_tdata  // red_out, green_out, blue_out
);

    import hsa_pkg::*;

    typedef struct packed {
        t_ch [NUM_CH-1:0] ch;
        t_ch [NUM_CH-1:0] d;
        t_ch              v;
        t_ch              delta;
    } t_s1;

    typedef struct packed {
        t_ch [NUM_CH-1:0]               ch;
        t_ch                            v;
        t_ch                            delta;
        logic [GPROD_W-1:0]             gd;
        logic [NUM_CH-1:0][GPROD_W-1:0] pg;
        logic [NUM_CH-1:0][PROD_W-1:0]  pv;
    } t_s2;

    logic [GAIN_W-1:0] r_gain;
    logic              w_adv;

    logic              r_s1_vld;
    logic              r_s2_vld;
    logic              r_dv_vld [DIV_STAGES+1];
    logic              r_out_vld;

    t_s1               n_s1;
    t_s1               r_s1;
    t_s2               n_s2;
    t_s2               r_s2;
    t_div              n_prep;
    t_div              n_dv     [DIV_STAGES+1];
    t_div              r_dv     [DIV_STAGES+1];
    logic [PIX_W-1:0]  n_out;
    logic [PIX_W-1:0]  r_out;

    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_ONE;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    // stage 1: max, min, differences
    always_comb begin
        t_ch mx;
        t_ch mn;
        for (int c = 0; c < NUM_CH; c++) begin
            n_s1.ch[c] = i_s_axis_tdata[c*CH_W +: CH_W];
        end
        mx = n_s1.ch[0];
        mn = n_s1.ch[0];
        for (int c = 1; c < NUM_CH; c++) begin
            if (n_s1.ch[c] > mx) begin
                mx = n_s1.ch[c];
            end
            if (n_s1.ch[c] < mn) begin
                mn = n_s1.ch[c];
            end
        end
        n_s1.v     = mx;
        n_s1.delta = mx - mn;
        for (int c = 0; c < NUM_CH; c++) begin
            n_s1.d[c] = mx - n_s1.ch[c];
        end
    end

    // stage 2: products
    always_comb begin
        n_s2.ch    = r_s1.ch;
        n_s2.v     = r_s1.v;
        n_s2.delta = r_s1.delta;
        n_s2.gd    = GPROD_W'(r_s1.delta) * GPROD_W'(r_gain);
        for (int c = 0; c < NUM_CH; c++) begin
            n_s2.pg[c] = GPROD_W'(r_s1.d[c]) * GPROD_W'(r_gain);
            n_s2.pv[c] = PROD_W'(r_s1.d[c]) * PROD_W'(r_s1.v);
        end
    end

    // stage 3: gain limit compare, rounded gain drop, divider dividend
    always_comb begin
        logic [GPROD_W:0] rnd;
        n_prep.ch    = r_s2.ch;
        n_prep.v     = r_s2.v;
        n_prep.delta = r_s2.delta;
        n_prep.grey  = (r_s2.delta == '0);
        n_prep.sel   = r_s2.gd > {4'b0, r_s2.v, {GAIN_FRAC{1'b0}}};
        n_prep.q     = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            rnd = (GPROD_W+1)'(r_s2.pg[c]) + (GPROD_W+1)'({GAIN_FRAC{1'b1}});
            n_prep.dg[c]  = rnd[GAIN_FRAC +: CH_W];
            n_prep.rem[c] = REM_W'(r_s2.pv[c]) + REM_W'(r_s2.delta) - REM_W'(1);
        end
    end

    // divider stages: ceil((v - ch) * v / delta), two quotient bits per stage
    always_comb begin
        logic [REM_W-1:0] sh;
        n_dv[0] = n_prep;
        for (int k = 0; k < DIV_STAGES; k++) begin
            n_dv[k+1] = r_dv[k];
            for (int c = 0; c < NUM_CH; c++) begin
                for (int b = 0; b < DIV_BITS_PER; b++) begin
                    sh = REM_W'(r_dv[k].delta) << (CH_W - 1 - k*DIV_BITS_PER - b);
                    if (n_dv[k+1].rem[c] >= sh) begin
                        n_dv[k+1].rem[c] = n_dv[k+1].rem[c] - sh;
                        n_dv[k+1].q[c][CH_W - 1 - k*DIV_BITS_PER - b] = 1'b1;
                    end
                end
            end
        end
    end

    // output: select drop, clamp, subtract; grey pixels pass through unchanged
    always_comb begin
        t_ch drop;
        for (int c = 0; c < NUM_CH; c++) begin
            drop = r_dv[DIV_STAGES].sel ? r_dv[DIV_STAGES].q[c] : r_dv[DIV_STAGES].dg[c];
            if (drop > r_dv[DIV_STAGES].v) begin
                drop = r_dv[DIV_STAGES].v;
            end
            if (r_dv[DIV_STAGES].grey) begin
                n_out[c*CH_W +: CH_W] = r_dv[DIV_STAGES].ch[c];
            end else begin
                n_out[c*CH_W +: CH_W] = r_dv[DIV_STAGES].v - drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_s1_vld    <= i_s_axis_tvalid;
            r_s2_vld    <= r_s1_vld;
            r_dv_vld[0] <= r_s2_vld;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
            r_out_vld   <= r_dv_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hsa_checker.sv
// ----------------------------------------------------------------------------
// hsa_checker
// port-level checks of the hsv saturation adjust stream and its occupancy
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_checker (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_s_axis_tvalid,
    input  wire                       o_s_axis_tready,
    input  wire                       o_m_axis_tvalid,
    input  wire                       i_m_axis_tready,
    input  wire [hsa_pkg::PIX_W-1:0]  o_m_axis_tdata
);

    import hsa_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

    logic [CNT_W-1:0] r_cnt;
    logic             w_in_xfer;
    logic             w_out_xfer;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer = o_m_axis_tvalid && i_m_axis_tready;

    // pixels accepted but not yet transferred out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(w_in_xfer) - CNT_W'(w_out_xfer);
        end
    end

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed under stall");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_cnt != '0)
        else $error("output valid with no pixel in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output empty");

endmodule

bind hsv_saturation_adjust hsa_checker u_hsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

FILE: tb/hsv_saturation_adjust_tb.sv
// ----------------------------------------------------------------------------
// hsv_saturation_adjust_tb
// streams rgb pixels through the saturation gain block and checks every
// output pixel against a behavioral predictor of the exact hsv round trip;
// a directed table covers grey pixels, zero gain, full saturation and the
// reset gain, then randomized phases sweep the gain register, with random
// backpressure and source gaps except in the final phase
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_saturation_adjust_tb;

    import hsa_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_PIXELS = 55;
    localparam int MAX_GAP      = 18;

    typedef struct packed {
        t_ch b;
        t_ch g;
        t_ch r;
    } t_pixel;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        t_pixel            pix;
        logic              known;
        t_pixel            result;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_valid;
    logic [GAIN_W-1:0]  cfg_data;
    logic               s_tvalid;
    logic [PIX_W-1:0]   s_tdata;
    logic               m_tready = 1'b0;
    wire                o_cfg_ready;
    wire                o_s_axis_tready;
    wire                o_m_axis_tvalid;
    wire [PIX_W-1:0]    o_m_axis_tdata;

    t_pixel             pixel_q[$];
    t_dir_row           dir_rows[$];
    logic [GAIN_W-1:0]  cur_gain;
    logic               idle_on;
    int                 ready_left = 0;
    int                 cycle_count = 0;
    int                 err_count = 0;
    int                 pixels_checked = 0;
    int                 gain_writes;

    hsv_saturation_adjust dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),        // red_in, green_in, blue_in
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)  // red_out, green_out, blue_out
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // exact saturation scaling, truncated toward zero
    function automatic t_pixel saturate_pixel(input t_pixel p, input logic [GAIN_W-1:0] gain);
        int unsigned c [3];
        int unsigned o [3];
        int unsigned v, lo, delta, num, den, drop;
        t_pixel      res;
        c[0] = 32'(p.r);
        c[1] = 32'(p.g);
        c[2] = 32'(p.b);
        v  = c[0];
        lo = c[0];
        for (int i = 1; i < 3; i++) begin
            if (c[i] > v) v = c[i];
            if (c[i] < lo) lo = c[i];
        end
        delta = v - lo;
        if (delta == 0) return p;
        if (32'(gain) * delta <= 32'(GAIN_ONE) * v) begin
            num = 32'(gain);
            den = 32'(GAIN_ONE);
        end else begin
            num = v;
            den = delta;
        end
        for (int i = 0; i < 3; i++) begin
            drop = ((v - c[i]) * num + den - 1) / den;
            if (drop > v) drop = v;
            o[i] = v - drop;
        end
        res.r = t_ch'(o[0]);
        res.g = t_ch'(o[1]);
        res.b = t_ch'(o[2]);
        return res;
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel      p;
        int unsigned kind;
        t_ch         base;
        kind = $urandom_range(0, 9);
        base = t_ch'($urandom);
        p.r  = t_ch'($urandom);
        p.g  = t_ch'($urandom);
        p.b  = t_ch'($urandom);
        case (kind)
            0: begin
                p.r = base;
                p.g = base;
                p.b = base;
            end
            1: begin
                base = t_ch'($urandom_range(0, 252));
                p.r  = t_ch'(32'(base) + $urandom_range(0, 3));
                p.g  = t_ch'(32'(base) + $urandom_range(0, 3));
                p.b  = t_ch'(32'(base) + $urandom_range(0, 3));
            end
            2: begin
                case ($urandom_range(0, 2))
                    0: p.r = 8'hff;
                    1: p.g = 8'hff;
                    default: p.b = 8'hff;
                endcase
            end
            3: begin
                p.r = t_ch'($urandom_range(0, 7));
                p.g = t_ch'($urandom_range(0, 7));
                p.b = t_ch'($urandom_range(0, 7));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic add_row(input logic [GAIN_W-1:0] gain, input t_ch r, input t_ch g,
                           input t_ch b, input logic known, input t_ch er, input t_ch eg,
                           input t_ch eb);
        t_dir_row row;
        row.gain   = gain;
        row.pix    = '{b: b, g: g, r: r};
        row.known  = known;
        row.result = '{b: eb, g: eg, r: er};
        dir_rows.push_back(row);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk) s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] gain);
        hold_until_drained();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_gain = gain;
        gain_writes++;
        @(negedge i_clk) cfg_valid <= 1'b0;
    endtask

    // one pixel transfer, optional source gap first
    task automatic send_pixel(input t_pixel p, input logic known, input t_pixel result);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk) s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pixel_q.push_back(known ? result : saturate_pixel(p, cur_gain));
    endtask

    // sink backpressure in random bursts
    always @(negedge i_clk) begin
        if (!idle_on) begin
            m_tready   <= 1'b1;
            ready_left = 0;
        end else if (ready_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                m_tready   <= 1'b0;
                ready_left = $urandom_range(0, MAX_GAP - 1);
            end else begin
                m_tready   <= 1'b1;
                ready_left = $urandom_range(0, 29);
            end
        end else begin
            ready_left--;
        end
    end

    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got = o_m_axis_tdata;
            if (pixel_q.size() == 0) begin
                $error("output transfer with no pixel pending: %h", got);
                err_count++;
            end else begin
                want = pixel_q.pop_front();
                pixels_checked++;
                if (got.r !== want.r) begin
                    $error("red_out mismatch: expected %0d, got %0d", want.r, got.r);
                    err_count++;
                end
                if (got.g !== want.g) begin
                    $error("green_out mismatch: expected %0d, got %0d", want.g, got.g);
                    err_count++;
                end
                if (got.b !== want.b) begin
                    $error("blue_out mismatch: expected %0d, got %0d", want.b, got.b);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hsv_saturation_adjust_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [GAIN_W-1:0] phase_gain [NUM_PHASES];
        t_dir_row          row;
        t_pixel            p;
        i_rst_n        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        idle_on        = 1'b1;
        cur_gain       = GAIN_ONE;
        gain_writes    = 0;

        // gain, pixel, typed result where obvious
        add_row(GAIN_ONE,   0,   0,   0, 1,   0,   0,   0);
        add_row(GAIN_ONE, 255, 255, 255, 1, 255, 255, 255);
        add_row(GAIN_ONE, 255,   0,   0, 1, 255,   0,   0);
        add_row(GAIN_ONE,  12, 200,  77, 1,  12, 200,  77);
        add_row(GAIN_ONE,   1,   2,   3, 1,   1,   2,   3);
        add_row(12'd0,    255,   0, 128, 1, 255, 255, 255);
        add_row(12'd0,     10,  20,  30, 1,  30,  30,  30);
        add_row(12'd0,     77,  77,  77, 1,  77,  77,  77);
        add_row(12'd4095, 200, 100, 150, 1, 200,   0, 100);
        add_row(12'd4095, 255, 254,   0, 1, 255, 254,   0);
        add_row(12'd4095,   1,   0,   0, 1,   1,   0,   0);
        add_row(12'd4095,   0,   0, 255, 1,   0,   0, 255);
        add_row(12'd4095, 128, 128, 128, 1, 128, 128, 128);
        add_row(12'd4095, 255, 254, 253, 0,   0,   0,   0);
        add_row(12'd4095,   3,   1,   2, 0,   0,   0,   0);
        add_row(12'd128,  200, 100, 150, 0,   0,   0,   0);
        add_row(12'd128,  255,   0,   1, 0,   0,   0,   0);
        add_row(12'd384,  100,  50,   0, 0,   0,   0,   0);
        add_row(12'd384,  100,  60,  90, 0,   0,   0,   0);
        add_row(12'd1,    255,   0,   0, 0,   0,   0,   0);
        add_row(12'd1,    254, 255, 253, 0,   0,   0,   0);
        add_row(12'd257,  255, 128,   0, 0,   0,   0,   0);
        add_row(12'd2048,  90,  80,  70, 0,   0,   0,   0);
        add_row(12'd2048, 170,  85, 255, 0,   0,   0,   0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.gain != cur_gain) write_gain(row.gain);
            send_pixel(row.pix, row.known, row.result);
        end

        phase_gain[0] = 12'd4095;
        phase_gain[1] = 12'd0;
        phase_gain[2] = GAIN_W'($urandom_range(0, 4095));
        phase_gain[3] = GAIN_ONE;
        phase_gain[4] = GAIN_W'($urandom_range(0, 511));
        phase_gain[5] = 12'd1;
        phase_gain[6] = GAIN_W'($urandom_range(0, 4095));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_gain(phase_gain[ph]);
            idle_on = (ph != NUM_PHASES - 1);
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                // source holds off until the pipeline is empty
                if (ph == 2 && k == PHASE_PIXELS / 2) hold_until_drained();
                p = random_pixel();
                send_pixel(p, 1'b0, p);
            end
        end

        hold_until_drained();
        repeat (PIPE_DEPTH * 4) @(posedge i_clk);

        $display("checked %0d output pixels, %0d directed rows", pixels_checked,
                 dir_rows.size());
        $display("gain register written %0d times, final gain %0d, %0d errors",
                 gain_writes, cur_gain, err_count);
        if (err_count == 0 && pixel_q.size() == 0) begin
            $display("hsv_saturation_adjust_tb OK");
        end else begin
            $display("hsv_saturation_adjust_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/hsa_pkg.sv
rtl/core/hsv_saturation_adjust.sv
rtl/core/hsa_checker.sv
tb/hsv_saturation_adjust_tb.sv
